>>> design/qbso_pkg.sv
// qbso_pkg: shared types, operation codes, constants and the sine table
// function of the sawtooth oscillator. No dependencies.
package qbso_pkg;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_DIV  = 4'd2;
	localparam logic [3:0] OP_W    = 4'd3;
	localparam logic [3:0] OP_D2   = 4'd4;
	localparam logic [3:0] OP_D4   = 4'd5;
	localparam logic [3:0] OP_B13  = 4'd6;
	localparam logic [3:0] OP_B    = 4'd7;
	localparam logic [3:0] OP_BZ   = 4'd8;
	localparam logic [3:0] OP_ROM  = 4'd9;
	localparam logic [3:0] OP_Z    = 4'd10;
	localparam logic [3:0] OP_OUT  = 4'd11;

	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam logic [26:0] C0376_Q28 = 27'd100931731;
	localparam logic [18:0] W_MAX_Q16 = 19'd262144;

	typedef struct packed {
		logic [3:0] op;
	} qbso_cmd_t;

	typedef struct packed {
		logic div_last;
	} qbso_sts_t;

	// Q1.14 sine entry k of a 2^ld table: quadrant fold plus Q30 Taylor series.
	// Evaluate only at elaboration to fill the constant table.
	function automatic logic signed [15:0] sine_value(input logic [11:0] k, input int ld);
		longint n4, q, r, x, x2, term, sum, v;
		n4 = 64'(k) * 4;
		q = n4 >>> ld;
		r = n4 & ((64'sd1 <<< ld) - 1);
		if (q[0])
			r = (64'sd1 <<< ld) - r;
		x = (r * HALF_PI_Q30) >>> ld;
		x2 = (x * x) >>> 30;
		term = x;
		sum = x;
		for (int i = 1; i <= 5; i++) begin
			term = -((term * x2) / 64'sd1073741824);
			unique case (i)
				1: term = term / 64'sd6;
				2: term = term / 64'sd20;
				3: term = term / 64'sd42;
				4: term = term / 64'sd72;
				default: term = term / 64'sd110;
			endcase
			sum = sum + term;
		end
		if (sum < 0)
			sum = 0;
		v = (sum + 32768) >>> 16;
		if (v > 16384)
			v = 16384;
		if (q >= 2)
			v = -v;
		return v[15:0];
	endfunction

endpackage

>>> design/qbso_dp.sv
// qbso_dp: oscillator datapath: restoring divider, multiply steps,
// sine table, feedback and phase state, output register. Uses qbso_pkg.
module qbso_dp import qbso_pkg::*; #(
	parameter int PHASE_BITS       = 24,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qbso_cmd_t         cmd,
	output qbso_sts_t         sts,
	input  logic [22:0]       in_freq,
	input  logic [14:0]       in_filt,
	input  logic              cfg_we,
	input  logic [17:0]       cfg_wdata,
	output logic signed [15:0] sample
);

	localparam int QW = PHASE_BITS + 15;
	localparam int CW = $clog2(QW);
	localparam int LD = $clog2(SINE_TABLE_DEPTH);

	logic [17:0]        rate_q;
	logic [14:0]        filt_q;
	logic [QW-1:0]      dvd_q;
	logic [17:0]        rem_q;
	logic [CW-1:0]      cnt_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic signed [15:0] z0_q, z1_q;
	logic [18:0]        w_q;
	logic signed [20:0] g_q;
	logic [19:0]        d2_q;
	logic [23:0]        d4_q;
	logic [27:0]        t13_q;
	logic [28:0]        b_q;
	logic signed [32:0] ct_q;
	logic [LD-1:0]      idx_q;
	logic signed [15:0] rom_q;
	logic signed [33:0] s28_q;
	logic signed [15:0] sample_q;

	logic [17:0]        divisor;
	logic [18:0]        rem2, rem_n;
	logic               ge;
	logic [30:0]        wq;
	logic signed [20:0] d16;
	logic signed [41:0] d2_full;
	logic [39:0]        d4_full;
	logic [42:0]        b_full;
	logic signed [48:0] ct_full;
	logic signed [45:0] bz_full;
	logic [16:0]        arg;
	logic signed [16:0] zsum;
	logic signed [15:0] z0n;
	logic signed [18:0] za, zb, zdiff;
	logic signed [54:0] out_full;
	logic signed [22:0] o;
	logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

	// Constant sine table, filled at elaboration.
	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic signed [15:0] SINE_K = sine_value(12'(k), LD);
		assign sine_rom[k] = SINE_K;
	end

	always_comb begin
		divisor = (rate_q == 18'd0) ? 18'd1 : rate_q;
		rem2 = {rem_q, dvd_q[QW-1]};
		ge = rem2 >= {1'b0, divisor};
		rem_n = ge ? (rem2 - {1'b0, divisor}) : rem2;
		wq = dvd_q[QW-1:PHASE_BITS-16];
		d16 = 21'sd32768 - $signed({2'b00, w_q});
		d2_full = d16 * d16;
		d4_full = {20'd0, d2_q} * {20'd0, d2_q};
		b_full = {15'd0, t13_q} * {28'd0, filt_q};
		ct_full = $signed({22'd0, C0376_Q28}) * $signed({{28{g_q[20]}}, g_q});
		bz_full = $signed({17'd0, b_q}) * $signed({{30{z0_q[15]}}, z0_q});
		arg = {phase_q[PHASE_BITS-1 -: 16], 1'b0} + 17'h10000 + bz_full[30:14];
		zsum = $signed({z0_q[15], z0_q}) + $signed({rom_q[15], rom_q});
		z0n = zsum[16:1];
		za = {{3{z0n[15]}}, z0n};
		zb = {{3{z1_q[15]}}, z1_q};
		zdiff = (za <<< 2) + za - ((zb <<< 1) + zb);
		out_full = $signed({{21{s28_q[33]}}, s28_q}) * $signed({{34{g_q[20]}}, g_q})
			+ (55'sd1 <<< 31);
		o = out_full[54:32];
	end

	assign sts.div_last = (cnt_q == CW'(QW - 1));

	// Control state: configuration, divider count, phase and feedback.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= 18'd44100;
			phase_q <= '0;
			z0_q    <= '0;
			z1_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we)
				rate_q <= cfg_wdata;
			if (cmd.op == OP_LOAD)
				cnt_q <= '0;
			else if (cmd.op == OP_DIV)
				cnt_q <= cnt_q + CW'(1);
			if (cmd.op == OP_W)
				phase_q <= phase_q + dvd_q[PHASE_BITS-1:0];
			if (cmd.op == OP_Z) begin
				z0_q <= z0n;
				z1_q <= z0n;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				filt_q <= in_filt;
				rem_q  <= '0;
				dvd_q  <= {in_freq, {(PHASE_BITS-8){1'b0}}};
			end
			OP_DIV: begin
				rem_q <= rem_n[17:0];
				dvd_q <= {dvd_q[QW-2:0], ge};
			end
			OP_W:   w_q <= (wq > {12'd0, W_MAX_Q16}) ? W_MAX_Q16 : wq[18:0];
			OP_D2: begin
				d2_q <= d2_full[35:16];
				g_q  <= 21'sd65536 - $signed({1'b0, w_q, 1'b0});
			end
			OP_D4:  d4_q <= d4_full[39:16];
			OP_B13: begin
				t13_q <= {1'b0, d4_q, 3'b000} + {2'b00, d4_q, 2'b00} + {4'd0, d4_q};
				ct_q  <= ct_full[48:16];
			end
			OP_B:   b_q <= b_full[42:14];
			OP_BZ:  idx_q <= arg[16 -: LD];
			OP_ROM: rom_q <= sine_rom[idx_q];
			OP_Z:   s28_q <= $signed({{2{zdiff[18]}}, zdiff, 13'd0})
				+ $signed({ct_q[32], ct_q});
			OP_OUT: begin
				if (o > 23'sd32767)
					sample_q <= 16'sh7fff;
				else if (o < -23'sd32768)
					sample_q <= -16'sd32768;
				else
					sample_q <= o[15:0];
			end
			default: ;
		endcase
	end

	assign sample = sample_q;

endmodule

>>> design/qbso_ctrl.sv
// qbso_ctrl: sequencer of the oscillator; drives datapath commands and the
// stream handshakes. Uses qbso_pkg.
module qbso_ctrl import qbso_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  qbso_sts_t sts,
	output qbso_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_W    = 4'd2;
	localparam logic [3:0] ST_D2   = 4'd3;
	localparam logic [3:0] ST_D4   = 4'd4;
	localparam logic [3:0] ST_B13  = 4'd5;
	localparam logic [3:0] ST_B    = 4'd6;
	localparam logic [3:0] ST_BZ   = 4'd7;
	localparam logic [3:0] ST_ROM  = 4'd8;
	localparam logic [3:0] ST_Z    = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0] state_q, state_n;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_n = state_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) begin
				cmd.op = OP_LOAD;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV;
				if (sts.div_last)
					state_n = ST_W;
			end
			ST_W:   begin cmd.op = OP_W;   state_n = ST_D2;  end
			ST_D2:  begin cmd.op = OP_D2;  state_n = ST_D4;  end
			ST_D4:  begin cmd.op = OP_D4;  state_n = ST_B13; end
			ST_B13: begin cmd.op = OP_B13; state_n = ST_B;   end
			ST_B:   begin cmd.op = OP_B;   state_n = ST_BZ;  end
			ST_BZ:  begin cmd.op = OP_BZ;  state_n = ST_ROM; end
			ST_ROM: begin cmd.op = OP_ROM; state_n = ST_Z;   end
			ST_Z:   begin cmd.op = OP_Z;   state_n = ST_OUT; end
			ST_OUT: if (out_free) begin
				cmd.op = OP_OUT;
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_DIV)
		else $error("accepted request did not start the divider");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !sts.div_last |=> state_q == ST_DIV)
		else $error("divider left early");

	a_out_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("result not presented after final step");

endmodule

>>> design/quasi_bandlimited_saw_oscillator.sv
// Quasi-bandlimited sawtooth oscillator: top level joining sequencer and datapath.
// Depends on qbso_pkg, qbso_ctrl, qbso_dp.
// Sequence: the bit-serial divider runs first, then the remaining steps; a new
//   request is taken only once the sequencer is idle again. A finished result
//   waits in the output register while the next request is taken, and a result
//   still held there stalls the sequencer in its last step.
// Reset: arst_n clears phase, feedback, sequencer; sample_rate returns to 44100.
module quasi_bandlimited_saw_oscillator import qbso_pkg::*; #(
	parameter int PHASE_BITS       = 24,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [22:0] frequency, [37:23] filter_amount, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample (signed Q3.12)
	input  logic        cfg_we,
	input  logic [17:0] cfg_wdata  // sample_rate in Hz
);

	qbso_cmd_t          cmd;
	qbso_sts_t          sts;
	logic signed [15:0] sample;

	// Sequencer: one state per datapath step, divider loop counted in the datapath.
	qbso_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: phase increment and normalized frequency from one division,
	// then feedback strength, sine lookup, feedback update and output scaling.
	qbso_dp #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_freq   (s_tdata[22:0]),
		.in_filt   (s_tdata[37:23]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample    (sample)
	);

	assign m_tdata = sample;

endmodule
